// File: sv/pcth_pkg.sv
// ----------------------------------------------------------------------------
// pcth_pkg
// Shared types and constants of the pin change trigger unit.
// ----------------------------------------------------------------------------
package pcth_pkg;

  // Width of one pin field; also the number of pins the packing can address.
  localparam int unsigned PinWidth  = 16;
  localparam int unsigned TimeWidth = 64;
  localparam int unsigned CfgWidth  = 16;

  // Input item kinds, carried on s_tuser.
  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_TICK  = 2'd1,
    OP_ARM   = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_USED_PINS     = 2'd0,
    CFG_HOLDOFF_TICKS = 2'd1,
    CFG_AUTO_ARMED    = 2'd2
  } cfg_idx_t;

  // Control from the execute stage to the hold-off counters.
  typedef struct packed {
    logic evt;   // a pin change event executes this cycle
    logic tick;  // a time tick executes this cycle
  } lane_ctl_t;

endpackage

// File: sv/pcth_lanes.sv
// ----------------------------------------------------------------------------
// pcth_lanes
// Per-pin hold-off counters and fire decision.
// ----------------------------------------------------------------------------
module pcth_lanes
  import pcth_pkg::*;
#(
  parameter int unsigned LANES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lane_ctl_t            ctl,
  input  logic [LANES-1:0]     flags,
  input  logic [LANES-1:0]     armed,
  input  logic [PinWidth-1:0]  holdoff_ticks,
  output logic [LANES-1:0]     fired
);

  logic [PinWidth-1:0] holdoff_left [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign fired[i] = flags[i] & armed[i] & (holdoff_left[i] == '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        holdoff_left[i] <= '0;
      end else if (ctl.evt && fired[i]) begin
        holdoff_left[i] <= holdoff_ticks;
      end else if (ctl.tick && holdoff_left[i] != '0) begin
        holdoff_left[i] <= holdoff_left[i] - 1'b1;
      end
    end
  end

endmodule

// File: sv/pcth_pack.sv
// ----------------------------------------------------------------------------
// pcth_pack
// Packs the bits selected by a mask down to the low end, in pin order.
// ----------------------------------------------------------------------------
module pcth_pack
  import pcth_pkg::*;
#(
  parameter int unsigned LANES = 16
) (
  input  logic [PinWidth-1:0] value,
  input  logic [PinWidth-1:0] sel,
  output logic [PinWidth-1:0] dout
);

  // Destination of each selected bit: the number of selected bits below it.
  logic [3:0] pos [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_pos
    localparam logic [PinWidth-1:0] BelowMask = PinWidth'((33'd1 << i) - 33'd1);
    assign pos[i] = 4'($countones(sel & BelowMask));
  end

  always_comb begin
    dout = '0;
    for (int j = 0; j < LANES; j++) begin
      for (int i = 0; i < LANES; i++) begin
        if (sel[i] && pos[i] == 4'(j)) begin
          dout[j] = dout[j] | value[i];
        end
      end
    end
  end

endmodule

// File: sv/pin_change_trigger_holdoff_core.sv
// ----------------------------------------------------------------------------
// pin_change_trigger_holdoff_core
// Sixteen-pin change trigger with per-pin hold-off and packed reports.
// ----------------------------------------------------------------------------
// Path: a report goes from the input register through the execute stage into the output register.
// Throughput: one item per cycle; the single execute stage after the input
// register sets this, and it stalls only while a report waits on m_tready.
// Reset (rst, synchronous): clears configuration, arms, hold-off counters and
// both valid flags.
module pin_change_trigger_holdoff_core
  import pcth_pkg::*;
#(
  parameter int unsigned PIN_COUNT = 16
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  // Input items.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,  // edge_flags, pin_levels, event_time, arm_mask
  input  logic [1:0]   s_tuser,  // op
  // Reports.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata   // fired_packed, snapshot_packed, report_time
);

  localparam int unsigned LANES = (PIN_COUNT < 16) ? PIN_COUNT : 16;

  // Configuration.
  logic [PinWidth-1:0] used_pins;
  logic [PinWidth-1:0] holdoff_ticks;
  logic [PinWidth-1:0] auto_armed;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_pins     <= '0;
      holdoff_ticks <= '0;
      auto_armed    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_USED_PINS:     used_pins     <= cfg_wdata;
        CFG_HOLDOFF_TICKS: holdoff_ticks <= cfg_wdata;
        CFG_AUTO_ARMED:    auto_armed    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  logic                 s1_valid;
  op_t                  s1_op;
  logic [PinWidth-1:0]  s1_flags;
  logic [PinWidth-1:0]  s1_levels;
  logic [TimeWidth-1:0] s1_time;
  logic [PinWidth-1:0]  s1_arm;

  logic      exec_go;
  logic      report;
  logic      out_free;
  lane_ctl_t lane_ctl;

  assign s_tready = !s1_valid || exec_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_op     <= op_t'(s_tuser);
      s1_flags  <= s_tdata[15:0];
      s1_levels <= s_tdata[31:16];
      s1_time   <= s_tdata[95:32];
      s1_arm    <= s_tdata[111:96];
    end
  end

  // Execute stage.
  logic [PinWidth-1:0] single_armed;
  logic [PinWidth-1:0] armed;
  logic [LANES-1:0]    fired;
  logic [PinWidth-1:0] fired_ext;
  logic [PinWidth-1:0] fired_packed;
  logic [PinWidth-1:0] snapshot_packed;

  assign armed    = single_armed | auto_armed;
  assign out_free = !m_tvalid || m_tready;
  assign report   = (s1_op == OP_EVENT) && (|fired);
  // Items without a report never wait on the output side.
  assign exec_go  = s1_valid && (!report || out_free);

  assign lane_ctl.evt  = exec_go && (s1_op == OP_EVENT);
  assign lane_ctl.tick = exec_go && (s1_op == OP_TICK);

  always_comb begin
    fired_ext = '0;
    fired_ext[LANES-1:0] = fired;
  end

  pcth_lanes #(.LANES(LANES)) u_lanes (
    .clk           (clk),
    .rst           (rst),
    .ctl           (lane_ctl),
    .flags         (s1_flags[LANES-1:0]),
    .armed         (armed[LANES-1:0]),
    .holdoff_ticks (holdoff_ticks),
    .fired         (fired)
  );

  pcth_pack #(.LANES(LANES)) u_pack_fired (
    .value (fired_ext),
    .sel   (used_pins),
    .dout  (fired_packed)
  );

  pcth_pack #(.LANES(LANES)) u_pack_levels (
    .value (s1_levels),
    .sel   (used_pins),
    .dout  (snapshot_packed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      single_armed <= '0;
    end else if (lane_ctl.evt) begin
      single_armed <= single_armed & ~fired_ext;
    end else if (exec_go && s1_op == OP_ARM) begin
      single_armed <= single_armed | s1_arm;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_go && report) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && report) begin
      m_tdata <= {s1_time, snapshot_packed, fired_packed};
    end
  end

endmodule

// File: sv/pcth_checker.sv
// ----------------------------------------------------------------------------
// pcth_checker
// Port-level assertions for the pin change trigger unit.
// ----------------------------------------------------------------------------
module pcth_checker
  import pcth_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata
);

  // A stalled report keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("report changed while stalled");

  // Reset leaves no report pending.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("report valid right after reset");

  // A fresh report comes from a pin change event accepted at the input port.
  a_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser == OP_EVENT, 2))
    else $error("report without a preceding event");

  // With no report held, nothing can block the input side.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input held off with the report register empty");

endmodule

bind pin_change_trigger_holdoff_core pcth_checker u_pcth_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
